// ----- design/svpd_pkg.sv -----
// Shared constants, types and helpers for the space vector PWM phase duty block.
// Used by svpd_horner_cell, svpd_sine and svpwm_phase_duty; depends on nothing.
package svpd_pkg;

	localparam int POSITIONS_PER_TURN = 1489;
	localparam int INDEX_FRAC_BITS    = 14;

	localparam int POS_W  = 11;
	localparam int IDX_W  = 15;
	localparam int DUTY_W = 16;

	// Angle scale: 65536 units per 60 degree sector.
	localparam int SECTOR_UNITS  = 65536;
	localparam int QUARTER_UNITS = 98304;
	localparam int TURN_UNITS    = 6 * SECTOR_UNITS;
	localparam int ANG_W         = 17;
	localparam int U_W           = $clog2(TURN_UNITS);

	// Position to angle is a multiplication by a scaled reciprocal of the turn length.
	localparam int     RCP_SH = 12;
	localparam longint RCP    = (longint'(TURN_UNITS) << RCP_SH) / POSITIONS_PER_TURN;
	localparam int     RCP_W  = $clog2(RCP + 1);
	localparam int     REM_W  = $clog2(2 * POSITIONS_PER_TURN);

	// Exact floor division by three for values below 2^18.
	localparam int DIV3_RCP = 349526;
	localparam int DIV3_SH  = 20;

	localparam int SIN_A      = 102944;
	localparam int SIN_B      = 42047;
	localparam int SIN_C      = 4640;
	localparam int SQRT3_HALF = 56755;
	localparam int SIN_CELLS  = 2;
	localparam int SIN_LAT    = 3 + SIN_CELLS;

	localparam int MS_W = 16 + IDX_W;

	localparam logic [2:0] SECTOR_0 = 3'd0;
	localparam logic [2:0] SECTOR_1 = 3'd1;
	localparam logic [2:0] SECTOR_2 = 3'd2;
	localparam logic [2:0] SECTOR_3 = 3'd3;
	localparam logic [2:0] SECTOR_4 = 3'd4;

	typedef struct packed {
		logic [ANG_W-1:0] z;
		logic [ANG_W-1:0] q;
		logic [ANG_W-1:0] acc;
	} horner_t;

	typedef struct packed {
		logic             oor;
		logic [2:0]       sector;
		logic [IDX_W-1:0] m;
		logic [MS_W-1:0]  ms;
		logic             neg3;
	} ctrl_t;

	// Horner coefficient for each cell of the sine polynomial, innermost first.
	function automatic logic [ANG_W-1:0] horner_coef(input int idx);
		logic [ANG_W-1:0] c;
		c = (idx == 0) ? ANG_W'(SIN_B) : ANG_W'(SIN_A);
		return c;
	endfunction

endpackage

// ----- design/svpd_horner_cell.sv -----
// One Horner step of the sine polynomial: acc <= coef - (acc * q >> 16).
// Depends on svpd_pkg.
module svpd_horner_cell (
	input  logic                              clk,
	input  logic                              en,
	input  logic [svpd_pkg::ANG_W-1:0]        coef,
	input  svpd_pkg::horner_t                 d_in,
	output svpd_pkg::horner_t                 d_out
);

	logic [2*svpd_pkg::ANG_W-1:0] prod;

	assign prod = (2*svpd_pkg::ANG_W)'(d_in.acc) * (2*svpd_pkg::ANG_W)'(d_in.q);

	always_ff @(posedge clk) begin
		if (en) begin
			d_out.z   <= d_in.z;
			d_out.q   <= d_in.q;
			d_out.acc <= coef - prod[16 +: svpd_pkg::ANG_W];
		end
	end

endmodule

// ----- design/svpd_sine.sv -----
// Pipelined Q16 sine of an angle in [0, 90 degrees] on the sector scale.
// Depends on svpd_pkg and svpd_horner_cell; registers the division, the square, each Horner cell and the product.
module svpd_sine (
	input  logic                       clk,
	input  logic                       en,
	input  logic [svpd_pkg::ANG_W-1:0] ang,
	output logic [svpd_pkg::ANG_W-1:0] sin_val
);

	logic [36:0]                  zp;
	logic [svpd_pkg::ANG_W-1:0]   z_s1;
	logic [2*svpd_pkg::ANG_W-1:0] zz;
	svpd_pkg::horner_t            chain [svpd_pkg::SIN_CELLS+1];
	logic [2*svpd_pkg::ANG_W-1:0] sp;
	logic [17:0]                  s_raw;

	// z = floor(2a/3) is the angle as a fraction of a quarter turn.
	assign zp = 37'({ang, 1'b0}) * 37'(svpd_pkg::DIV3_RCP);
	assign zz = (2*svpd_pkg::ANG_W)'(z_s1) * (2*svpd_pkg::ANG_W)'(z_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1         <= zp[svpd_pkg::DIV3_SH +: svpd_pkg::ANG_W];
			chain[0].z   <= z_s1;
			chain[0].q   <= zz[16 +: svpd_pkg::ANG_W];
			chain[0].acc <= svpd_pkg::ANG_W'(svpd_pkg::SIN_C);
		end
	end

	for (genvar k = 0; k < svpd_pkg::SIN_CELLS; k++) begin : g_cell
		svpd_horner_cell u_cell (
			.clk   (clk),
			.en    (en),
			.coef  (svpd_pkg::horner_coef(k)),
			.d_in  (chain[k]),
			.d_out (chain[k+1])
		);
	end

	assign sp    = (2*svpd_pkg::ANG_W)'(chain[svpd_pkg::SIN_CELLS].z) *
	               (2*svpd_pkg::ANG_W)'(chain[svpd_pkg::SIN_CELLS].acc);
	assign s_raw = sp[16 +: 18];

	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= (s_raw > 18'(svpd_pkg::SECTOR_UNITS)) ?
			           svpd_pkg::ANG_W'(svpd_pkg::SECTOR_UNITS) : s_raw[svpd_pkg::ANG_W-1:0];
		end
	end

endmodule

// ----- design/svpwm_phase_duty.sv -----
// Top level of the space vector PWM phase duty block: angle, four sine lanes, times, duty.
// Depends on svpd_pkg and svpd_sine.
//
//  channel  direction  payload (low bit first)                       handshake
//  s_axis   in         tdata: shaft_pos[10:0], m_index[25:11]         tvalid/tready
//  m_axis   out        tdata: duty_count[15:0]                        tvalid/tready
//  cfg      in         data: max_duty[15:0]                           valid/ready
//
// One item a cycle while the output is not stalled.
// The sine lanes are each five cells long: reciprocal, square, two Horner cells, product.
// A stalled output freezes the whole pipeline, so ready follows the output register.
// Reset clears the valid chain and sets max_duty to 1500; the configuration port is always ready.
module svpwm_phase_duty (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // shaft_pos[10:0], m_index[25:11]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // duty_count[15:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int NSTG = 16;
	localparam int F    = svpd_pkg::INDEX_FRAC_BITS;
	localparam int AW   = svpd_pkg::ANG_W;
	localparam int PW   = svpd_pkg::MS_W + AW;
	localparam int MCW  = svpd_pkg::IDX_W + AW;
	localparam int XW   = 38;
	localparam int DW   = 56;
	localparam int PRW  = svpd_pkg::POS_W + svpd_pkg::RCP_W;
	localparam int RMW  = svpd_pkg::POS_W + svpd_pkg::U_W + 1;
	localparam logic signed [XW-1:0] Q32_ONE_X = XW'(64'h1_0000_0000);

	logic [NSTG-1:0] vld_q;
	logic            en;
	logic [15:0]     max_duty_q;

	// Stage 1 to 3: angle.
	logic [svpd_pkg::POS_W-1:0] pos_in, pos_s1;
	logic [svpd_pkg::IDX_W-1:0] m_in, m_s1, m_s2;
	logic                       oor_s1, oor_s2;
	logic [PRW-1:0]             prod_s1;
	logic [svpd_pkg::U_W-1:0]   u_est, u_est_s2, u;
	logic [RMW-1:0]             rem_full;
	logic [svpd_pkg::REM_W-1:0] rem_s2;
	logic [15:0]                theta;
	logic [17:0]                x3;
	logic                       neg3;
	logic [AW-1:0]              ang_s3 [4];
	svpd_pkg::ctrl_t            ctrl_s3;
	svpd_pkg::ctrl_t            ctrl_dq [svpd_pkg::SIN_LAT];
	svpd_pkg::ctrl_t            c8;
	logic [AW-1:0]              sin_s8 [4];

	// Stage 9 onwards: times and duty.
	logic [PW-1:0]           p1_s9, p2_s9;
	logic [MCW-1:0]          mc1_s9, w3_s9;
	logic [2:0]              sector_s9;
	logic                    oor_s9, oor_s10, oor_s11, oor_s12, oor_s13, oor_s14, oor_s15;
	logic                    neg3_s9, neg3_s10, neg3_s11;
	logic signed [XW-1:0]    r1x, r2x, x_sel, x_s10, x_s11, x_s12;
	logic                    e_sel, e_s10, e_s11;
	logic signed [XW-1:0]    term1_s10, term1_s11;
	logic [47:0]             h;
	logic [47:0]             base3_s10, t3_s11;
	logic [17:0]             dsum_s10;
	logic [37:0]             dq;
	logic signed [XW-1:0]    t3s, bsum, brk_s12;
	logic signed [16:0]      mxs, mhs;
	logic signed [37:0]      pah_s13, pbh_s13;
	logic [32:0]             pal_s13, pbl_s13;
	logic signed [DW-1:0]    a_s14, b_s14, duty_s15;
	logic [DW-34:0]          hi;
	logic [15:0]             out_q;

	assign en            = !vld_q[NSTG-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[NSTG-1];
	assign m_axis_tdata  = out_q;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			max_duty_q <= 16'd1500;
		end else begin
			if (en) vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
			if (cfg_valid) max_duty_q <= cfg_data;
		end
	end

	assign pos_in = s_axis_tdata[svpd_pkg::POS_W-1:0];
	assign m_in   = s_axis_tdata[svpd_pkg::POS_W +: svpd_pkg::IDX_W];

	assign u_est    = prod_s1[svpd_pkg::RCP_SH +: svpd_pkg::U_W];
	assign rem_full = RMW'(pos_s1) * RMW'(svpd_pkg::TURN_UNITS)
	                - RMW'(svpd_pkg::POSITIONS_PER_TURN) * RMW'(u_est);

	// The reciprocal estimate is at most one low; the remainder corrects it.
	assign u     = u_est_s2 + svpd_pkg::U_W'(rem_s2 >= svpd_pkg::REM_W'(svpd_pkg::POSITIONS_PER_TURN));
	assign theta = u[15:0];
	assign x3    = {2'b0, theta} + {1'b0, theta, 1'b0};
	assign neg3  = x3 > 18'(svpd_pkg::QUARTER_UNITS);

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1   <= pos_in;
			m_s1     <= m_in;
			oor_s1   <= {1'b0, pos_in} >= (svpd_pkg::POS_W+1)'(svpd_pkg::POSITIONS_PER_TURN);
			prod_s1  <= PRW'(pos_in) * PRW'(svpd_pkg::RCP);

			u_est_s2 <= u_est;
			rem_s2   <= rem_full[svpd_pkg::REM_W-1:0];
			m_s2     <= m_s1;
			oor_s2   <= oor_s1;

			ang_s3[0] <= AW'(svpd_pkg::SECTOR_UNITS) - {1'b0, theta};
			ang_s3[1] <= {1'b0, theta};
			ang_s3[2] <= AW'(svpd_pkg::QUARTER_UNITS) - {1'b0, theta};
			ang_s3[3] <= neg3 ? AW'(x3 - 18'(svpd_pkg::QUARTER_UNITS))
			                  : AW'(18'(svpd_pkg::QUARTER_UNITS) - x3);
			ctrl_s3.oor    <= oor_s2;
			ctrl_s3.sector <= u[svpd_pkg::U_W-1:16];
			ctrl_s3.m      <= m_s2;
			ctrl_s3.ms     <= svpd_pkg::MS_W'(m_s2) * svpd_pkg::MS_W'(svpd_pkg::SQRT3_HALF);
			ctrl_s3.neg3   <= neg3;

			ctrl_dq[0] <= ctrl_s3;
			for (int k = 1; k < svpd_pkg::SIN_LAT; k++) ctrl_dq[k] <= ctrl_dq[k-1];
		end
	end

	// Lanes: sin(60 - theta), sin(theta), cos(theta), |cos(3 theta)|.
	for (genvar i = 0; i < 4; i++) begin : g_lane
		svpd_sine u_sine (
			.clk     (clk),
			.en      (en),
			.ang     (ang_s3[i]),
			.sin_val (sin_s8[i])
		);
	end

	assign c8  = ctrl_dq[svpd_pkg::SIN_LAT-1];
	assign r1x = $signed(XW'(p1_s9 >> F));
	assign r2x = $signed(XW'(p2_s9 >> F));

	// The duty is max * X + (max >> 1) * bracket, with the signs chosen by sector.
	always_comb begin
		unique case (sector_s9)
			svpd_pkg::SECTOR_0: begin x_sel = Q32_ONE_X;             e_sel = 1'b1; end
			svpd_pkg::SECTOR_1: begin x_sel = r1x;                   e_sel = 1'b0; end
			svpd_pkg::SECTOR_2: begin x_sel = Q32_ONE_X - r1x - r2x; e_sel = 1'b1; end
			svpd_pkg::SECTOR_3: begin x_sel = '0;                    e_sel = 1'b0; end
			svpd_pkg::SECTOR_4: begin x_sel = Q32_ONE_X - r1x;       e_sel = 1'b1; end
			default:            begin x_sel = r1x + r2x;             e_sel = 1'b0; end
		endcase
	end

	// Division of the third-harmonic term by six: halve, then split into 16-bit digits
	// and use 2^16 = 1 modulo 3.
	assign h    = (48'(w3_s9) << (16 - F)) >> 1;
	assign dq   = 38'(dsum_s10) * 38'(svpd_pkg::DIV3_RCP);
	assign t3s  = $signed(XW'(t3_s11));
	assign bsum = term1_s11 + (neg3_s11 ? -t3s : t3s);
	assign mxs  = $signed({1'b0, max_duty_q});
	assign mhs  = $signed({2'b0, max_duty_q[15:1]});
	assign hi   = duty_s15[DW-2:32];

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s9     <= PW'(c8.ms) * PW'(sin_s8[0]);
			p2_s9     <= PW'(c8.ms) * PW'(sin_s8[1]);
			mc1_s9    <= MCW'(c8.m) * MCW'(sin_s8[2]);
			w3_s9     <= MCW'(c8.m) * MCW'(sin_s8[3]);
			sector_s9 <= c8.sector;
			oor_s9    <= c8.oor;
			neg3_s9   <= c8.neg3;

			x_s10     <= x_sel;
			e_s10     <= e_sel;
			term1_s10 <= Q32_ONE_X - $signed(XW'(mc1_s9) << (16 - F));
			base3_s10 <= 48'(h[47:32]) * 48'(32'd1431655765) + 48'(h[31:16]) * 48'(16'd21845);
			dsum_s10  <= 18'(h[15:0]) + 18'(h[31:16]) + 18'(h[47:32]);
			oor_s10   <= oor_s9;
			neg3_s10  <= neg3_s9;

			t3_s11    <= base3_s10 + 48'(dq[svpd_pkg::DIV3_SH +: 17]);
			term1_s11 <= term1_s10;
			x_s11     <= x_s10;
			e_s11     <= e_s10;
			neg3_s11  <= neg3_s10;
			oor_s11   <= oor_s10;

			brk_s12   <= e_s11 ? -bsum : bsum;
			x_s12     <= x_s11;
			oor_s12   <= oor_s11;

			pah_s13   <= $signed(x_s12[XW-1:17]) * mxs;
			pal_s13   <= 33'(x_s12[16:0]) * 33'(max_duty_q);
			pbh_s13   <= $signed(brk_s12[XW-1:17]) * mhs;
			pbl_s13   <= 33'(brk_s12[16:0]) * 33'(max_duty_q[15:1]);
			oor_s13   <= oor_s12;

			a_s14     <= (DW'(pah_s13) <<< 17) + $signed(DW'(pal_s13));
			b_s14     <= (DW'(pbh_s13) <<< 17) + $signed(DW'(pbl_s13));
			oor_s14   <= oor_s13;

			duty_s15  <= a_s14 + b_s14;
			oor_s15   <= oor_s14;

			if (oor_s15 || duty_s15[DW-1]) out_q <= '0;
			else if (hi > (DW-33)'(max_duty_q)) out_q <= max_duty_q;
			else out_q <= hi[15:0];
		end
	end

	a_duty_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata <= max_duty_q))
		else $error("duty_count exceeds max_duty");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_q[0])
		else $error("accepted transfer did not enter the pipeline");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with an empty output register");

endmodule

// ----- tb/sv/tb_svpwm_phase_duty.sv -----
// Self-checking testbench for the space vector PWM phase duty block.
// Predicts each duty count in fixed point and compares it with every output transfer.
// Depends on svpd_pkg and svpwm_phase_duty.
module tb_svpwm_phase_duty;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 16;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // shaft_pos[10:0], m_index[25:11]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // duty_count[15:0]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	logic [15:0] period_count;
	logic [15:0] duty_queue[$];
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          failed;

	svpwm_phase_duty dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Polynomial sine on the 65536-per-sector scale, result in Q16.
	function automatic longint sine_q16(longint a);
		longint z, q, p, s;
		if (a > 2 * svpd_pkg::QUARTER_UNITS)
			a = 2 * svpd_pkg::QUARTER_UNITS;
		if (a > svpd_pkg::QUARTER_UNITS)
			a = 2 * svpd_pkg::QUARTER_UNITS - a;
		z = (a * 2) / 3;
		q = (z * z) >>> 16;
		p = svpd_pkg::SIN_B - ((svpd_pkg::SIN_C * q) >>> 16);
		p = svpd_pkg::SIN_A - ((p * q) >>> 16);
		s = (z * p) >>> 16;
		if (s > 65536)
			s = 65536;
		return s;
	endfunction

	function automatic logic [15:0] phase_duty(logic [10:0] pos, logic [14:0] idx,
			logic [15:0] period);
		longint m, mx, u, sector, theta, s1, s2, c1, c3, t1, t2, t0, t7, bracket, duty;
		longint one;
		one = 64'sd1 <<< 32;
		m = idx;
		mx = period;
		if (pos >= svpd_pkg::POSITIONS_PER_TURN)
			return 16'd0;
		u = (longint'(pos) * 6 * svpd_pkg::SECTOR_UNITS) / svpd_pkg::POSITIONS_PER_TURN;
		sector = u >>> 16;
		theta = u & 16'hFFFF;
		s1 = sine_q16(svpd_pkg::SECTOR_UNITS - theta);
		s2 = sine_q16(theta);
		c1 = sine_q16(svpd_pkg::QUARTER_UNITS - theta);
		if (3 * theta <= svpd_pkg::QUARTER_UNITS)
			c3 = sine_q16(svpd_pkg::QUARTER_UNITS - 3 * theta);
		else
			c3 = -sine_q16(3 * theta - svpd_pkg::QUARTER_UNITS);
		t1 = ((svpd_pkg::SQRT3_HALF * m * s1) >>> svpd_pkg::INDEX_FRAC_BITS) * mx;
		t2 = ((svpd_pkg::SQRT3_HALF * m * s2) >>> svpd_pkg::INDEX_FRAC_BITS) * mx;
		bracket = one - m * c1 * (1 << (16 - svpd_pkg::INDEX_FRAC_BITS))
			+ (m * c3 * (1 << (16 - svpd_pkg::INDEX_FRAC_BITS))) / 6;
		t0 = (mx >>> 1) * bracket;
		t7 = mx * one - t1 - t2 - t0;
		case (sector)
			0: duty = t1 + t2 + t7;
			1: duty = t1 + t0;
			2: duty = t7;
			3: duty = t0;
			4: duty = t2 + t7;
			default: duty = t1 + t2 + t0;
		endcase
		if (duty < 0)
			duty = 0;
		else
			duty = duty >>> 32;
		if (duty > mx)
			duty = mx;
		return duty[15:0];
	endfunction

	// Result checker and receiver stalls.
	always @(posedge clk) begin
		logic [15:0] want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (duty_queue.size() == 0) begin
				$display("%0t: unexpected duty transfer, expected none, actual %0d",
					$time, m_axis_tdata);
				failed = 1'b1;
			end else begin
				want = duty_queue.pop_front();
				if (m_axis_tdata !== want) begin
					$display("%0t: duty_count mismatch, expected %0d, actual %0d",
						$time, want, m_axis_tdata);
					failed = 1'b1;
				end
			end
		end
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Valid stays high after the transfer until an idle gap before the next item, or drain, takes it down.
	task automatic send_sample(logic [10:0] pos, logic [14:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, idx, pos};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		duty_queue = {duty_queue, phase_duty(pos, idx, period_count)};
		@(negedge clk);
	endtask

	task automatic drain;
		int guard;
		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (duty_queue.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_period(logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		period_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed;
		send_sample(11'd0, 15'd0);
		send_sample(11'd0, 15'd16384);
		send_sample(11'd1488, 15'd18919);
		send_sample(11'd1489, 15'd16384);
		send_sample(11'd2047, 15'd32767);
		send_sample(11'd744, 15'd32767);
		for (int k = 0; k < 6; k++) begin
			send_sample(11'((k * svpd_pkg::POSITIONS_PER_TURN) / 6), 15'd18919);
			send_sample(11'((k * svpd_pkg::POSITIONS_PER_TURN) / 6 + 124), 15'd8192);
		end
		send_sample(11'd1024, 15'h5555);
		send_sample(11'd682, 15'h2AAA);
	endtask

	task automatic test_random(int count);
		logic [10:0] pos;
		logic [14:0] idx;
		for (int k = 0; k < count; k++) begin
			pos = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(1488));
			case ($urandom_range(3))
				0: idx = 15'($urandom);
				1: idx = 15'($urandom_range(18919));
				default: idx = 15'($urandom_range(16384));
			endcase
			send_sample(pos, idx);
		end
	endtask

	task automatic test_periods;
		write_period(16'd1);
		test_directed();
		test_random(60);
		write_period(16'hFFFF);
		test_directed();
		test_random(60);
		write_period(16'd0);
		test_random(20);
		write_period(16'($urandom_range(65535, 2)));
		test_random(80);
		write_period(16'd1500);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		period_count = 16'd1500;
		failed = 1'b0;
		send_idle_pct = 31;
		recv_idle_pct = 77;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(200);
		send_idle_pct = 77;
		recv_idle_pct = 31;
		test_random(200);
		test_periods();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(250);
		drain();
		if (!failed)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
